/* rtl/circ_pkg.sv */
package circ_pkg;

    localparam int MAX_MIN_RUN      = 16;
    localparam int INDEXED_FLAG_BIT = 31;
    localparam int K_W              = (MAX_MIN_RUN > 1) ? $clog2(MAX_MIN_RUN) : 1;

    localparam logic [31:0] LEGACY_BYTES  = 32'd12;
    localparam logic [31:0] INDEXED_BYTES = 32'd4;

    localparam logic [1:0] KIND_DIRECT  = 2'd0;
    localparam logic [1:0] KIND_INDEXED = 2'd1;
    localparam logic [1:0] KIND_TABLE   = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic CFG_MIN_RUN     = 1'b0;
    localparam logic CFG_INDEX_STORE = 1'b1;

    typedef struct packed {
        logic [31:0] handle;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] range_start;
        logic [31:0] range_count;
        logic [31:0] table_addr;
        logic [31:0] table_value;
        logic [31:0] direct_range_total;
        logic [31:0] direct_item_total;
        logic [31:0] indexed_range_total;
        logic [31:0] indexed_item_total;
        logic [31:0] input_item_total;
        logic [31:0] bytes_saved;
        logic        end_of_results;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic extend;
        logic close_run;
        logic open_run;
        logic flush;
        logic emit_long;
        logic emit_short;
        logic k_clr;
        logic k_inc;
        logic calc;
        logic emit_sum;
        logic end_flag;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic extend_ok;
        logic run_zero;
        logic run_long;
        logic pend_any;
        logic k_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/consecutive_id_run_compactor_core.sv */
// Takes one handle word per accept and emits result words on a registered output
// channel: direct ranges, indexed ranges, table writes and a batch summary after the
// word marked last. The block handles one input word at a time and takes no new word
// until it is through with the last one. A word that extends the open run only grows
// it; a word that closes a long run first flushes the pending table entries and then
// emits the range, and a short run emits one table write or single per handle (up to
// 15). A last word adds the final flush, the byte count and the summary, and when it
// opens a new run, that one-handle run is closed first. A full output register stalls
// every emit until it is taken.
// Configuration (index 0 min_run, index 1 index_store_present) must be written only
// while idle; the block itself does not enforce it.
module consecutive_id_run_compactor_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  circ_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output circ_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [4:0]          i_cfg_data
);
    import circ_pkg::*;

    t_cmd cmd;
    t_sts sts;

    circ_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    circ_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

/* rtl/circ_dp.sv */
module circ_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  circ_pkg::t_cmd      i_cmd,
    output circ_pkg::t_sts      o_sts,
    input  circ_pkg::t_in_word  i_in_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [4:0]          i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output circ_pkg::t_out_word o_out_word
);
    import circ_pkg::*;

    logic [4:0]     r_min_run, n_min_run;
    logic           r_store, n_store;
    logic [31:0]    r_h, n_h;
    logic           r_last, n_last;
    logic [31:0]    r_run_first, n_run_first;
    logic [31:0]    r_run_len, n_run_len;
    logic [31:0]    r_pend_cnt, n_pend_cnt;
    logic [31:0]    r_pend_first, n_pend_first;
    logic [31:0]    r_tab_ptr, n_tab_ptr;
    logic [31:0]    r_items, n_items;
    logic [31:0]    r_dr, n_dr;
    logic [31:0]    r_di, n_di;
    logic [31:0]    r_ir, n_ir;
    logic [31:0]    r_ii, n_ii;
    logic [K_W-1:0] r_k, n_k;
    logic [31:0]    r_full, n_full;
    logic [31:0]    r_used, n_used;
    logic           r_out_valid, n_out_valid;
    t_out_word      r_out, n_out;

    logic [4:0]  eff;
    logic [31:0] short_val;
    logic        out_free;

    always_comb begin
        if (r_min_run == 5'd0) begin
            eff = 5'd1;
        end else if (32'(r_min_run) > 32'(MAX_MIN_RUN)) begin
            eff = 5'(MAX_MIN_RUN);
        end else begin
            eff = r_min_run;
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign short_val = r_run_first + 32'(r_k);

    assign o_sts.last      = r_last;
    assign o_sts.extend_ok = (r_run_len != 32'd0) && (r_run_len != '1) &&
                             (r_h == r_run_first + r_run_len);
    assign o_sts.run_zero  = (r_run_len == 32'd0);
    assign o_sts.run_long  = (r_run_len >= 32'(eff));
    assign o_sts.pend_any  = (r_pend_cnt != 32'd0);
    assign o_sts.k_last    = (r_run_len == 32'(r_k) + 32'd1);
    assign o_sts.out_free  = out_free;

    always_comb begin
        n_min_run    = r_min_run;
        n_store      = r_store;
        n_h          = r_h;
        n_last       = r_last;
        n_run_first  = r_run_first;
        n_run_len    = r_run_len;
        n_pend_cnt   = r_pend_cnt;
        n_pend_first = r_pend_first;
        n_tab_ptr    = r_tab_ptr;
        n_items      = r_items;
        n_dr         = r_dr;
        n_di         = r_di;
        n_ir         = r_ir;
        n_ii         = r_ii;
        n_k          = r_k;
        n_full       = r_full;
        n_used       = r_used;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_RUN:     n_min_run = i_cfg_data;
                CFG_INDEX_STORE: n_store   = i_cfg_data[0];
                default:         n_store   = r_store;
            endcase
        end

        if (i_cmd.load) begin
            n_h     = i_in_word.handle;
            n_last  = i_in_word.last;
            n_items = r_items + 32'd1;
        end
        if (i_cmd.extend) begin
            n_run_len = r_run_len + 32'd1;
        end
        if (i_cmd.k_clr) begin
            n_k = '0;
        end
        if (i_cmd.k_inc) begin
            n_k = r_k + K_W'(1);
        end

        if (i_cmd.flush) begin
            if (r_pend_cnt >= 32'd2) begin
                n_out = '0;
                n_out.kind        = KIND_INDEXED;
                n_out.range_start = r_tab_ptr | (32'd1 << INDEXED_FLAG_BIT);
                n_out.range_count = r_pend_cnt;
                n_out_valid       = 1'b1;
                n_ir      = r_ir + 32'd1;
                n_ii      = r_ii + r_pend_cnt;
                n_tab_ptr = r_tab_ptr + r_pend_cnt;
            end else if (r_pend_cnt == 32'd1) begin
                n_out = '0;
                n_out.kind        = KIND_DIRECT;
                n_out.range_start = r_pend_first;
                n_out.range_count = 32'd1;
                n_out_valid       = 1'b1;
                n_dr = r_dr + 32'd1;
                n_di = r_di + 32'd1;
            end
            n_pend_cnt   = 32'd0;
            n_pend_first = 32'd0;
        end

        if (i_cmd.emit_long) begin
            n_out = '0;
            n_out.kind           = KIND_DIRECT;
            n_out.range_start    = r_run_first;
            n_out.range_count    = r_run_len;
            n_out.end_of_results = i_cmd.end_flag;
            n_out_valid          = 1'b1;
            n_dr = r_dr + 32'd1;
            n_di = r_di + r_run_len;
        end

        if (i_cmd.emit_short) begin
            n_out = '0;
            n_out.end_of_results = i_cmd.end_flag;
            n_out_valid          = 1'b1;
            if (r_store) begin
                if (r_pend_cnt == 32'd0) begin
                    n_pend_first = r_run_first;
                end
                n_out.kind        = KIND_TABLE;
                n_out.table_addr  = r_tab_ptr + r_pend_cnt;
                n_out.table_value = short_val;
                n_pend_cnt        = r_pend_cnt + 32'd1;
            end else begin
                n_out.kind        = KIND_DIRECT;
                n_out.range_start = short_val;
                n_out.range_count = 32'd1;
                n_dr = r_dr + 32'd1;
                n_di = r_di + 32'd1;
            end
        end

        if (i_cmd.close_run) begin
            n_run_len = 32'd0;
        end
        if (i_cmd.open_run) begin
            n_run_first = r_h;
            n_run_len   = 32'd1;
        end

        if (i_cmd.calc) begin
            n_full = r_items * LEGACY_BYTES;
            n_used = r_ii * INDEXED_BYTES;
        end

        if (i_cmd.emit_sum) begin
            n_out = '0;
            n_out.kind                = KIND_SUMMARY;
            n_out.direct_range_total  = r_dr;
            n_out.direct_item_total   = r_di;
            n_out.indexed_range_total = r_ir;
            n_out.indexed_item_total  = r_ii;
            n_out.input_item_total    = r_items;
            n_out.bytes_saved         = (r_full >= r_used) ? (r_full - r_used) : 32'd0;
            n_out.end_of_results      = i_cmd.end_flag;
            n_out_valid               = 1'b1;
            n_run_first  = 32'd0;
            n_run_len    = 32'd0;
            n_pend_cnt   = 32'd0;
            n_pend_first = 32'd0;
            n_items      = 32'd0;
            n_dr         = 32'd0;
            n_di         = 32'd0;
            n_ir         = 32'd0;
            n_ii         = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run    <= 5'd1;
            r_store      <= 1'b1;
            r_run_first  <= '0;
            r_run_len    <= '0;
            r_pend_cnt   <= '0;
            r_pend_first <= '0;
            r_tab_ptr    <= '0;
            r_items      <= '0;
            r_dr         <= '0;
            r_di         <= '0;
            r_ir         <= '0;
            r_ii         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_min_run    <= n_min_run;
            r_store      <= n_store;
            r_run_first  <= n_run_first;
            r_run_len    <= n_run_len;
            r_pend_cnt   <= n_pend_cnt;
            r_pend_first <= n_pend_first;
            r_tab_ptr    <= n_tab_ptr;
            r_items      <= n_items;
            r_dr         <= n_dr;
            r_di         <= n_di;
            r_ir         <= n_ir;
            r_ii         <= n_ii;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_last <= n_last;
        r_k    <= n_k;
        r_full <= n_full;
        r_used <= n_used;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_sum |=> (r_run_len == 32'd0 && r_pend_cnt == 32'd0 && r_items == 32'd0))
        else $error("batch state not cleared after summary");

endmodule

/* rtl/circ_ctrl.sv */
module circ_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  circ_pkg::t_sts i_sts,
    output circ_pkg::t_cmd o_cmd
);
    import circ_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EVAL    = 4'd1;
    localparam logic [3:0] S_CLOSE   = 4'd2;
    localparam logic [3:0] S_FLUSH_A = 4'd3;
    localparam logic [3:0] S_LONG    = 4'd4;
    localparam logic [3:0] S_SHORT   = 4'd5;
    localparam logic [3:0] S_AFTER   = 4'd6;
    localparam logic [3:0] S_FFLUSH  = 4'd7;
    localparam logic [3:0] S_CALC    = 4'd8;
    localparam logic [3:0] S_SUM     = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_final, n_final;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.extend_ok) begin
                    cmd.extend = 1'b1;
                    if (i_sts.last) begin
                        n_final = 1'b1;
                        n_state = S_CLOSE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_final = 1'b0;
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (i_sts.run_zero) begin
                    n_state = S_AFTER;
                end else if (i_sts.run_long) begin
                    n_state = S_FLUSH_A;
                end else begin
                    cmd.k_clr = 1'b1;
                    n_state   = S_SHORT;
                end
            end
            S_FLUSH_A: begin
                if (!i_sts.pend_any || i_sts.out_free) begin
                    cmd.flush = 1'b1;
                    n_state   = S_LONG;
                end
            end
            S_LONG: begin
                if (i_sts.out_free) begin
                    cmd.emit_long = 1'b1;
                    cmd.end_flag  = !i_sts.last;
                    n_state       = S_AFTER;
                end
            end
            S_SHORT: begin
                if (i_sts.out_free) begin
                    cmd.emit_short = 1'b1;
                    cmd.end_flag   = !i_sts.last && i_sts.k_last;
                    if (i_sts.k_last) begin
                        n_state = S_AFTER;
                    end else begin
                        cmd.k_inc = 1'b1;
                    end
                end
            end
            S_AFTER: begin
                cmd.close_run = 1'b1;
                if (!r_final) begin
                    cmd.open_run = 1'b1;
                    if (i_sts.last) begin
                        n_final = 1'b1;
                        n_state = S_CLOSE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_FFLUSH;
                end
            end
            S_FFLUSH: begin
                if (!i_sts.pend_any || i_sts.out_free) begin
                    cmd.flush = 1'b1;
                    n_state   = S_CALC;
                end
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                n_state  = S_SUM;
            end
            S_SUM: begin
                if (i_sts.out_free) begin
                    cmd.emit_sum = 1'b1;
                    cmd.end_flag = 1'b1;
                    n_final      = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_long || cmd.emit_short || cmd.emit_sum ||
         (cmd.flush && i_sts.pend_any)) |-> i_sts.out_free)
        else $error("word emitted into a full output register");

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.flush, cmd.emit_long, cmd.emit_short, cmd.emit_sum}))
        else $error("two emit commands in one cycle");

    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_sum |=> (r_state == S_IDLE && !r_final))
        else $error("controller not idle after summary");

endmodule

/* bench/consecutive_id_run_compactor_core_test.sv */
`timescale 1ns / 100ps

import circ_pkg::*;

class run_compactor_board;
    t_out_word   expected_q[$];
    int unsigned errors;
    logic [4:0]  min_run;
    logic        store_on;
    logic [31:0] run_first;
    logic [31:0] run_len;
    logic [31:0] pend_count;
    logic [31:0] pend_first;
    logic [31:0] tbl_ptr;
    logic [31:0] batch_items;
    logic [31:0] dir_range_cnt;
    logic [31:0] dir_item_cnt;
    logic [31:0] idx_range_cnt;
    logic [31:0] idx_item_cnt;

    function new();
        errors   = 0;
        min_run  = 5'd1;
        store_on = 1'b1;
        tbl_ptr  = '0;
        clear_batch();
    endfunction

    function void clear_batch();
        run_first     = '0;
        run_len       = '0;
        pend_count    = '0;
        pend_first    = '0;
        batch_items   = '0;
        dir_range_cnt = '0;
        dir_item_cnt  = '0;
        idx_range_cnt = '0;
        idx_item_cnt  = '0;
    endfunction

    function void set_reg(logic idx, logic [4:0] data);
        if (idx == CFG_MIN_RUN) begin
            min_run = data;
        end else begin
            store_on = data[0];
        end
    endfunction

    function int unsigned eff_min_run();
        if (min_run == 5'd0) begin
            return 1;
        end
        if (min_run > MAX_MIN_RUN) begin
            return MAX_MIN_RUN;
        end
        return min_run;
    endfunction

    function void push_word(logic [1:0] kind, logic [31:0] start, logic [31:0] count,
                            logic [31:0] addr, logic [31:0] value);
        t_out_word w;
        w             = '0;
        w.kind        = kind;
        w.range_start = start;
        w.range_count = count;
        w.table_addr  = addr;
        w.table_value = value;
        expected_q.push_back(w);
    endfunction

    function void push_direct(logic [31:0] start, logic [31:0] count);
        push_word(KIND_DIRECT, start, count, '0, '0);
        dir_range_cnt += 1;
        dir_item_cnt  += count;
    endfunction

    function void flush_pending();
        if (pend_count >= 2) begin
            push_word(KIND_INDEXED, tbl_ptr | (32'd1 << INDEXED_FLAG_BIT), pend_count, '0, '0);
            idx_range_cnt += 1;
            idx_item_cnt  += pend_count;
            tbl_ptr       += pend_count;
        end else if (pend_count == 1) begin
            push_direct(pend_first, 32'd1);
        end
        pend_count = '0;
        pend_first = '0;
    endfunction

    function void close_run();
        logic [31:0] k;
        if (run_len == 0) begin
            return;
        end
        if (run_len >= eff_min_run()) begin
            flush_pending();
            push_direct(run_first, run_len);
        end else if (store_on) begin
            for (k = 0; k < run_len; k++) begin
                if (pend_count == 0) begin
                    pend_first = run_first;
                end
                push_word(KIND_TABLE, '0, '0, tbl_ptr + pend_count, run_first + k);
                pend_count += 1;
            end
        end else begin
            for (k = 0; k < run_len; k++) begin
                push_direct(run_first + k, 32'd1);
            end
        end
        run_len = '0;
    endfunction

    function void note_handle(logic [31:0] handle, logic last);
        int unsigned queued_n;
        logic [31:0] full_bytes;
        logic [31:0] used_bytes;
        t_out_word   w;
        queued_n    = expected_q.size();
        batch_items += 1;
        if (run_len != 0 && run_len != 32'hFFFF_FFFF && handle == run_first + run_len) begin
            run_len += 1;
        end else begin
            close_run();
            run_first = handle;
            run_len   = 32'd1;
        end
        if (last) begin
            close_run();
            flush_pending();
            full_bytes            = batch_items * LEGACY_BYTES;
            used_bytes            = idx_item_cnt * INDEXED_BYTES;
            w                     = '0;
            w.kind                = KIND_SUMMARY;
            w.direct_range_total  = dir_range_cnt;
            w.direct_item_total   = dir_item_cnt;
            w.indexed_range_total = idx_range_cnt;
            w.indexed_item_total  = idx_item_cnt;
            w.input_item_total    = batch_items;
            w.bytes_saved         = (full_bytes >= used_bytes) ? full_bytes - used_bytes : '0;
            expected_q.push_back(w);
            clear_batch();
        end
        if (expected_q.size() > queued_n) begin
            w = expected_q.pop_back();
            w.end_of_results = 1'b1;
            expected_q.push_back(w);
        end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    function void check_word(t_out_word got);
        t_out_word want;
        if (expected_q.size() == 0) begin
            $error("unexpected result word: kind %0d start %h", got.kind, got.range_start);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        cmp_field("kind", 32'(want.kind), 32'(got.kind));
        cmp_field("range_start", want.range_start, got.range_start);
        cmp_field("range_count", want.range_count, got.range_count);
        cmp_field("table_addr", want.table_addr, got.table_addr);
        cmp_field("table_value", want.table_value, got.table_value);
        cmp_field("direct_range_total", want.direct_range_total, got.direct_range_total);
        cmp_field("direct_item_total", want.direct_item_total, got.direct_item_total);
        cmp_field("indexed_range_total", want.indexed_range_total, got.indexed_range_total);
        cmp_field("indexed_item_total", want.indexed_item_total, got.indexed_item_total);
        cmp_field("input_item_total", want.input_item_total, got.input_item_total);
        cmp_field("bytes_saved", want.bytes_saved, got.bytes_saved);
        cmp_field("end_of_results", 32'(want.end_of_results), 32'(got.end_of_results));
    endfunction
endclass

module consecutive_id_run_compactor_core_test;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned HOLD_AT_WORD  = 150;
    localparam int unsigned PHASE_ITEMS   = 55;
    localparam int unsigned PHASE_COUNT   = 7;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [4:0] i_cfg_data;

    run_compactor_board board;

    int unsigned cycles     = 0;
    int unsigned words_seen = 0;
    int unsigned in_burst   = 0;
    int unsigned out_burst  = 0;
    int unsigned out_gap    = 0;
    bit          held_off   = 1'b0;

    consecutive_id_run_compactor_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned draw_gap(inout int unsigned burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    initial begin : result_side
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                board.check_word(o_out_word);
                words_seen++;
                out_gap = draw_gap(out_burst);
                if (!held_off && words_seen == HOLD_AT_WORD) begin
                    out_gap  = HOLD_CYCLES;
                    held_off = 1'b1;
                end
            end
            @(negedge i_clk);
            if (out_gap > 0) begin
                i_out_ready = 1'b0;
                out_gap--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_handle(logic [31:0] handle, logic last);
        int unsigned gap;
        gap = draw_gap(in_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word.handle = handle;
        i_in_word.last   = last;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_handle(handle, last);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic send_random_batch(output int unsigned sent);
        int unsigned runs;
        int unsigned r;
        int unsigned len;
        int unsigned k;
        int unsigned eff;
        int unsigned pick;
        bit          noisy;
        logic [31:0] next_handle;
        logic [31:0] start;
        eff         = board.eff_min_run();
        runs        = $urandom_range(1, 6);
        noisy       = ($urandom_range(0, 7) == 0);
        sent        = 0;
        next_handle = $urandom();
        for (r = 0; r < runs; r++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                len = $urandom_range(1, (eff > 1) ? eff - 1 : 1);
            end else if (pick < 8) begin
                len = $urandom_range(eff, eff + 4);
            end else begin
                len = $urandom_range(1, 3);
            end
            case ($urandom_range(0, 7))
                0: start = 32'hFFFF_FFFF - $urandom_range(0, 3);
                1: start = next_handle + 1;
                2: start = next_handle;
                3: start = next_handle - 1;
                default: start = $urandom();
            endcase
            for (k = 0; k < len; k++) begin
                send_handle(noisy ? 32'($urandom()) : start + k,
                            (r == runs - 1) && (k == len - 1));
                sent++;
            end
            next_handle = start + len;
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_items;
        int unsigned sent;
        logic [4:0]  cfg_min;
        logic        cfg_store;
        board      = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_MIN_RUN;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_MIN_RUN, 5'd3);
        write_reg(CFG_INDEX_STORE, 5'd1);

        // short runs gather in the table, then a long run across the wrap flushes them
        send_handle(32'h0000_000A, 1'b0);
        send_handle(32'h0000_0014, 1'b0);
        send_handle(32'h0000_0015, 1'b0);
        send_handle(32'hFFFF_FFFE, 1'b0);
        send_handle(32'hFFFF_FFFF, 1'b0);
        send_handle(32'h0000_0000, 1'b1);
        // lone pending handle: direct single, pointer holds
        send_handle(32'h0000_0005, 1'b1);
        send_handle(32'hAAAA_AAAA, 1'b0);
        send_handle(32'h5555_5555, 1'b1);
        // drop the store while two handles sit in the table
        send_handle(32'h0000_0064, 1'b0);
        send_handle(32'h0000_00C8, 1'b0);
        send_handle(32'h0000_012C, 1'b0);
        settle();
        write_reg(CFG_INDEX_STORE, 5'd0);
        send_handle(32'h0000_0190, 1'b1);
        send_handle(32'h0000_0007, 1'b0);
        send_handle(32'h0000_0008, 1'b0);
        send_handle(32'h0000_0014, 1'b0);
        send_handle(32'h0000_0015, 1'b0);
        send_handle(32'h0000_0016, 1'b0);
        send_handle(32'h0000_0017, 1'b1);

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                0: begin cfg_min = 5'd1;  cfg_store = 1'b1; end
                1: begin cfg_min = 5'd0;  cfg_store = 1'b0; end
                2: begin cfg_min = 5'd5;  cfg_store = 1'b1; end
                3: begin cfg_min = 5'd31; cfg_store = 1'b1; end
                4: begin cfg_min = 5'd16; cfg_store = 1'b0; end
                5: begin cfg_min = 5'd2;  cfg_store = 1'b1; end
                default: begin cfg_min = 5'd8; cfg_store = 1'b1; end
            endcase
            write_reg(CFG_MIN_RUN, cfg_min);
            write_reg(CFG_INDEX_STORE, {4'd0, cfg_store});
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                send_random_batch(sent);
                phase_items += sent;
            end
        end

        settle();
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
